### rtl/rss_pkg.sv
// rss_pkg: shared constants, state and control types of the radius scan statistic block.
// Used by the channel interfaces, the accumulator, the shared arithmetic unit and the top level.
package rss_pkg;

    localparam int MAX_POINTS_DEF = 1024;

    localparam int DIST_W  = 24;
    localparam int CONS_W  = 24;
    localparam int RAD_W   = 16;
    localparam int NUM_W   = 11;
    localparam int STAT_W  = 24;
    localparam int LEN_W   = 8;
    localparam int NORM_W  = 64;
    localparam int MANT_W  = 32;
    localparam int FRAC_W  = 30;
    localparam int KEXP_W  = 6;
    localparam int STEP_W  = 5;
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    localparam int LOG_STEPS = 30;
    localparam int LN_SHIFT  = 24;
    localparam int STAT_SHIFT = 23;
    localparam int LOG_OFFSET = 16;

    localparam logic [PADDR_W-1:0] REG_RADIUS = 2'd0;

    localparam logic [23:0]              LN2_Q24    = 24'd11629080;
    localparam logic signed [STAT_W-1:0] STAT_MAX   = 24'sh7FFFFF;
    localparam logic signed [STAT_W-1:0] STAT_MIN   = 24'sh800000;
    localparam logic [NUM_W-1:0]         CENTRE_MAX = '1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_DMUL,
        S_DMULW,
        S_DDIVW,
        S_VDIV,
        S_VDIVW,
        S_NORM,
        S_LMUL,
        S_LMULW,
        S_LN,
        S_LNW,
        S_STATW,
        S_FIN
    } t_state;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } t_alu_op;

    typedef struct packed {
        logic             start;
        t_alu_op          op;
        logic [LEN_W-1:0] len;
    } t_alu_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_stat;

    typedef struct packed {
        logic load;
        logic add;
        logic clear;
    } t_acc_ctrl;

endpackage

### rtl/rss_in_if.sv
// rss_in_if: input item channel of the radius scan statistic block.
// Depends on rss_pkg for field widths.
interface rss_in_if import rss_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic [CONS_W-1:0] consumption;
    logic              last_neighbour;
    logic              first_centre;

    modport source (output valid, distance, consumption, last_neighbour, first_centre,
                    input ready);
    modport sink   (input valid, distance, consumption, last_neighbour, first_centre,
                    output ready);
endinterface

### rtl/rss_out_if.sv
// rss_out_if: result item channel of the radius scan statistic block.
// Depends on rss_pkg for field widths.
interface rss_out_if import rss_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [NUM_W-1:0]         centre_number;
    logic [NUM_W-1:0]         inside_count;
    logic signed [STAT_W-1:0] statistic;
    logic signed [STAT_W-1:0] best_statistic;
    logic                     zero_variance;

    modport source (output valid, centre_number, inside_count, statistic, best_statistic,
                    zero_variance, input ready);
    modport sink   (input valid, centre_number, inside_count, statistic, best_statistic,
                    zero_variance, output ready);
endinterface

### rtl/rss_acc.sv
// rss_acc: per-group counts, sums and sums of squares with a registered squarer.
// Depends on rss_pkg; driven by the sequencer in the top level.
module rss_acc import rss_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    localparam int CNT_W = $clog2(MAX_POINTS + 1),
    localparam int SUM_W = CONS_W + $clog2(MAX_POINTS),
    localparam int SQ_W  = 2 * CONS_W + $clog2(MAX_POINTS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_acc_ctrl         i_ctrl,
    input  logic              i_inside,
    input  logic [CONS_W-1:0] i_cons,
    output logic [CNT_W-1:0]  o_cnt_in,
    output logic [CNT_W-1:0]  o_cnt_out,
    output logic [SUM_W-1:0]  o_sum_in,
    output logic [SUM_W-1:0]  o_sum_out,
    output logic [SQ_W-1:0]   o_sq_in,
    output logic [SQ_W-1:0]   o_sq_out
);

    logic                  r_inside;
    logic [CONS_W-1:0]     r_cons;
    logic [2*CONS_W-1:0]   r_sq;
    logic [CNT_W-1:0]      r_cnt_in, r_cnt_out;
    logic [SUM_W-1:0]      r_sum_in, r_sum_out;
    logic [SQ_W-1:0]       r_sq_in, r_sq_out;
    logic [CNT_W:0]        n_total;
    logic                  room;

    assign n_total = {1'b0, r_cnt_in} + {1'b0, r_cnt_out};
    assign room    = n_total < (CNT_W + 1)'(MAX_POINTS);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_inside <= i_inside;
            r_cons   <= i_cons;
            r_sq     <= i_cons * i_cons;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_cnt_in  <= '0;
            r_cnt_out <= '0;
            r_sum_in  <= '0;
            r_sum_out <= '0;
            r_sq_in   <= '0;
            r_sq_out  <= '0;
        end else if (i_ctrl.add && room) begin
            if (r_inside) begin
                r_cnt_in <= r_cnt_in + 1'b1;
                r_sum_in <= r_sum_in + SUM_W'(r_cons);
                r_sq_in  <= r_sq_in + SQ_W'(r_sq);
            end else begin
                r_cnt_out <= r_cnt_out + 1'b1;
                r_sum_out <= r_sum_out + SUM_W'(r_cons);
                r_sq_out  <= r_sq_out + SQ_W'(r_sq);
            end
        end
    end

    assign o_cnt_in  = r_cnt_in;
    assign o_cnt_out = r_cnt_out;
    assign o_sum_in  = r_sum_in;
    assign o_sum_out = r_sum_out;
    assign o_sq_in   = r_sq_in;
    assign o_sq_out  = r_sq_out;

endmodule

### rtl/rss_alu.sv
// rss_alu: shared shift-add multiplier and restoring divider, one bit per cycle.
// Depends on rss_pkg for the command and status types.
module rss_alu import rss_pkg::*; #(
    parameter int MW = NORM_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_alu_cmd      i_cmd,
    input  logic [MW-1:0] i_a,
    input  logic [MW-1:0] i_b,
    output t_alu_stat     o_stat,
    output logic [MW-1:0] o_prod,
    output logic [MW-1:0] o_quot
);

    logic             r_busy, r_done;
    t_alu_op          r_op;
    logic [LEN_W-1:0] r_cnt;
    logic [MW-1:0]    r_a, r_b, r_acc;
    logic [MW-1:0]    rem_sh, add_sum;
    logic             rem_ge;

    assign rem_sh  = {r_acc[MW-2:0], r_b[MW-1]};
    assign rem_ge  = rem_sh >= r_a;
    assign add_sum = r_acc + (r_b[0] ? r_a : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == LEN_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op  <= i_cmd.op;
            r_cnt <= i_cmd.len;
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            case (r_op)
                OP_MUL: begin
                    r_acc <= add_sum;
                    r_a   <= {r_a[MW-2:0], 1'b0};
                    r_b   <= {1'b0, r_b[MW-1:1]};
                end
                OP_DIV: begin
                    r_acc <= rem_ge ? rem_sh - r_a : rem_sh;
                    r_b   <= {r_b[MW-2:0], rem_ge};
                end
                default: begin
                    r_acc <= r_acc;
                end
            endcase
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_prod      = r_acc;
    assign o_quot      = r_b;

endmodule

### rtl/radius_scan_statistic.sv
// radius_scan_statistic: top level with sequencer, configuration port and result register.
// Depends on rss_pkg, rss_in_if, rss_out_if, rss_acc and rss_alu.
//
// Each neighbour item is first registered with its square and then added to its group, and
// the block is not ready in between. The item marked last_neighbour then runs the closing
// sequence on one shared bit-serial multiply/divide unit: per non-empty group a square and
// a divide, the variance divide, a normalize, 30 log steps, a scale and a multiply by N,
// plus control; a zero total count or a zero variance skips to a saturated result.
// A finished result waits in an output register and the next row may start meanwhile.
module radius_scan_statistic import rss_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rss_in_if.sink             i_in,
    rss_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SUM_W = CONS_W + $clog2(MAX_POINTS);
    localparam int SQ_W  = 2 * CONS_W + $clog2(MAX_POINTS);
    localparam int TOT_W = SQ_W + 1;
    localparam int MW    = (2 * SUM_W > NORM_W) ? 2 * SUM_W : NORM_W;
    localparam int LW    = KEXP_W + 1 + FRAC_W;

    t_state                   r_state, n_state;
    logic [RAD_W-1:0]         r_radius;
    logic                     r_last, r_grp, r_zero, r_lneg;
    logic [TOT_W-1:0]         r_total;
    logic [NORM_W-1:0]        r_m;
    logic [KEXP_W-1:0]        r_k;
    logic [MANT_W-1:0]        r_mant;
    logic [FRAC_W-1:0]        r_frac;
    logic [STEP_W-1:0]        r_i;
    logic signed [STAT_W-1:0] r_stat, r_best;
    logic                     r_best_valid;
    logic [NUM_W-1:0]         r_centre;
    logic                     r_out_valid;
    logic [NUM_W-1:0]         r_out_centre, r_out_inside;
    logic signed [STAT_W-1:0] r_out_stat, r_out_best;
    logic                     r_out_zero;

    t_acc_ctrl         acc_ctrl;
    t_alu_cmd          alu_cmd;
    t_alu_stat         alu_stat;
    logic [MW-1:0]     alu_a, alu_b, alu_prod, alu_quot;
    logic [CNT_W-1:0]  cnt_in, cnt_out, n_g, n_tot;
    logic [SUM_W-1:0]  sum_in, sum_out, s_g;
    logic [SQ_W-1:0]   sq_in, sq_out, sq_g, dev_g;
    logic              in_acc, is_near, out_load, upd_best;
    logic [32:0]       m2;
    logic signed [KEXP_W:0] k_off;
    logic [LW-1:0]     l_val, l_mag;
    logic [MW-1:0]     mag_ln, mag_s;
    logic signed [STAT_W-1:0] stat_calc;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_RADIUS) ? PDATA_W'(r_radius) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
        end else if (psel && penable && pwrite && paddr == REG_RADIUS) begin
            r_radius <= pwdata[RAD_W-1:0];
        end
    end

    assign in_acc  = i_in.valid && i_in.ready;
    assign is_near = i_in.distance <= {r_radius, 8'h00};

    rss_acc #(.MAX_POINTS(MAX_POINTS)) u_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (acc_ctrl),
        .i_inside  (is_near),
        .i_cons    (i_in.consumption),
        .o_cnt_in  (cnt_in),
        .o_cnt_out (cnt_out),
        .o_sum_in  (sum_in),
        .o_sum_out (sum_out),
        .o_sq_in   (sq_in),
        .o_sq_out  (sq_out)
    );

    rss_alu #(.MW(MW)) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (alu_cmd),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_stat  (alu_stat),
        .o_prod  (alu_prod),
        .o_quot  (alu_quot)
    );

    assign n_g   = r_grp ? cnt_out : cnt_in;
    assign s_g   = r_grp ? sum_out : sum_in;
    assign sq_g  = r_grp ? sq_out : sq_in;
    assign n_tot = cnt_in + cnt_out;
    assign dev_g = (alu_quot > MW'(sq_g)) ? '0 : sq_g - SQ_W'(alu_quot);

    assign m2     = alu_prod[63:31];
    assign k_off  = $signed({1'b0, r_k}) - (KEXP_W + 1)'(LOG_OFFSET);
    assign l_val  = {k_off, r_frac};
    assign l_mag  = l_val[LW-1] ? -l_val : l_val;
    assign mag_ln = alu_prod >> LN_SHIFT;
    assign mag_s  = (alu_prod + (MW'(1) << (STAT_SHIFT - 1))) >> STAT_SHIFT;

    always_comb begin
        if (!r_lneg) begin
            stat_calc = (mag_s > MW'(unsigned'(STAT_MIN))) ? STAT_MIN : -$signed(mag_s[23:0]);
        end else begin
            stat_calc = (mag_s > MW'(STAT_MAX)) ? STAT_MAX : $signed(mag_s[23:0]);
        end
    end

    assign out_load = (r_state == S_FIN) && (!r_out_valid || o_out.ready);
    assign upd_best = !r_best_valid || (r_stat > r_best);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in.valid) n_state = S_ACC;
            S_ACC:   n_state = r_last ? S_DMUL : S_IDLE;
            S_DMUL:  n_state = (n_g == '0) ? (r_grp ? S_VDIV : S_DMUL) : S_DMULW;
            S_DMULW: if (alu_stat.done) n_state = S_DDIVW;
            S_DDIVW: if (alu_stat.done) n_state = r_grp ? S_VDIV : S_DMUL;
            S_VDIV:  n_state = (n_tot == '0) ? S_FIN : S_VDIVW;
            S_VDIVW: if (alu_stat.done) n_state = (alu_quot == '0) ? S_FIN : S_NORM;
            S_NORM:  if (r_m[NORM_W-1]) n_state = S_LMUL;
            S_LMUL:  n_state = S_LMULW;
            S_LMULW: begin
                if (alu_stat.done) begin
                    n_state = (r_i == STEP_W'(LOG_STEPS - 1)) ? S_LN : S_LMUL;
                end
            end
            S_LN:    n_state = S_LNW;
            S_LNW:   if (alu_stat.done) n_state = S_STATW;
            S_STATW: if (alu_stat.done) n_state = S_FIN;
            S_FIN:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready     = (r_state == S_IDLE);
        acc_ctrl.load  = in_acc;
        acc_ctrl.add   = (r_state == S_ACC);
        acc_ctrl.clear = (in_acc && i_in.first_centre) || out_load;
        alu_cmd.start  = 1'b0;
        alu_cmd.op     = OP_MUL;
        alu_cmd.len    = LEN_W'(MW);
        alu_a          = '0;
        alu_b          = '0;
        case (r_state)
            S_DMUL: begin
                alu_cmd.start = (n_g != '0);
                alu_cmd.len   = LEN_W'(SUM_W);
                alu_a         = MW'(s_g);
                alu_b         = MW'(s_g);
            end
            S_DMULW: begin
                alu_cmd.start = alu_stat.done;
                alu_cmd.op    = OP_DIV;
                alu_a         = MW'(n_g);
                alu_b         = alu_prod;
            end
            S_VDIV: begin
                alu_cmd.start = (n_tot != '0);
                alu_cmd.op    = OP_DIV;
                alu_a         = MW'(n_tot);
                alu_b         = MW'(r_total);
            end
            S_LMUL: begin
                alu_cmd.start = 1'b1;
                alu_cmd.len   = LEN_W'(MANT_W);
                alu_a         = MW'(r_mant);
                alu_b         = MW'(r_mant);
            end
            S_LN: begin
                alu_cmd.start = 1'b1;
                alu_cmd.len   = LEN_W'(LN_SHIFT);
                alu_a         = MW'(l_mag);
                alu_b         = MW'(LN2_Q24);
            end
            S_LNW: begin
                alu_cmd.start = alu_stat.done;
                alu_cmd.len   = LEN_W'(CNT_W);
                alu_a         = mag_ln;
                alu_b         = MW'(n_tot);
            end
            default: begin
                alu_cmd.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) r_last <= i_in.last_neighbour;
            end
            S_ACC: begin
                r_total <= '0;
                r_grp   <= 1'b0;
                r_zero  <= 1'b0;
            end
            S_DMUL: begin
                if (n_g == '0) r_grp <= 1'b1;
            end
            S_DDIVW: begin
                if (alu_stat.done) begin
                    r_total <= r_total + TOT_W'(dev_g);
                    r_grp   <= 1'b1;
                end
            end
            S_VDIV: begin
                if (n_tot == '0) begin
                    r_zero <= 1'b1;
                    r_stat <= STAT_MAX;
                end
            end
            S_VDIVW: begin
                if (alu_stat.done) begin
                    r_m <= alu_quot[NORM_W-1:0];
                    r_k <= '1;
                    if (alu_quot == '0) begin
                        r_zero <= 1'b1;
                        r_stat <= STAT_MAX;
                    end
                end
            end
            S_NORM: begin
                if (r_m[NORM_W-1]) begin
                    r_mant <= r_m[NORM_W-1 -: MANT_W];
                    r_frac <= '0;
                    r_i    <= '0;
                end else begin
                    r_m <= {r_m[NORM_W-2:0], 1'b0};
                    r_k <= r_k - 1'b1;
                end
            end
            S_LMULW: begin
                if (alu_stat.done) begin
                    r_frac <= {r_frac[FRAC_W-2:0], m2[32]};
                    r_mant <= m2[32] ? m2[32:1] : m2[31:0];
                    r_i    <= r_i + 1'b1;
                end
            end
            S_LN: begin
                r_lneg <= l_val[LW-1];
            end
            S_STATW: begin
                if (alu_stat.done) r_stat <= stat_calc;
            end
            default: begin
                r_last <= r_last;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre     <= '0;
            r_best       <= '0;
            r_best_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_acc && i_in.first_centre) begin
                r_centre     <= '0;
                r_best       <= '0;
                r_best_valid <= 1'b0;
            end else if (out_load) begin
                if (upd_best) begin
                    r_best       <= r_stat;
                    r_best_valid <= 1'b1;
                end
                if (r_centre != CENTRE_MAX) r_centre <= r_centre + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_centre <= (r_centre != CENTRE_MAX) ? r_centre + 1'b1 : r_centre;
            r_out_inside <= NUM_W'(cnt_in);
            r_out_stat   <= r_stat;
            r_out_best   <= upd_best ? r_stat : r_best;
            r_out_zero   <= r_zero;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.centre_number  = r_out_centre;
    assign o_out.inside_count   = r_out_inside;
    assign o_out.statistic      = r_out_stat;
    assign o_out.best_statistic = r_out_best;
    assign o_out.zero_variance  = r_out_zero;

endmodule

### rtl/rss_checker.sv
// rss_checker: port-level assertions for radius_scan_statistic, attached by bind.
// Depends on rss_pkg for widths and the saturation constant.
module rss_checker import rss_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     i_in_ready,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic signed [STAT_W-1:0] i_stat,
    input logic signed [STAT_W-1:0] i_best,
    input logic                     i_zero
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_stat))
        else $error("result item dropped or changed while stalled");

    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while previous item still in work");

    a_zero_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_zero |-> i_stat == STAT_MAX)
        else $error("zero variance without saturated statistic");

    a_best_ge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_best >= i_stat)
        else $error("best statistic below current statistic");

endmodule

bind radius_scan_statistic rss_checker u_rss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_stat      (o_out.statistic),
    .i_best      (o_out.best_statistic),
    .i_zero      (o_out.zero_variance)
);
